@@ rtl/core/sdft_pkg.sv @@
`default_nettype none

package sdft_pkg;

  // Samples per fundamental period (power of two)
  localparam int unsigned CYCLE_SAMPLES = 256;
  localparam int unsigned PHASE_W       = $clog2(CYCLE_SAMPLES);

  // Field and datapath widths
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned TRIG_W   = 16;
  localparam int unsigned COEF_W   = 40;
  localparam int unsigned PROD_W   = COEF_W + TRIG_W;
  localparam int unsigned SUM_W    = PROD_W + 1;
  localparam int unsigned FRAC_W   = 30;
  localparam int unsigned FUND_W   = SUM_W - FRAC_W;
  localparam int unsigned DIFF_W   = FUND_W + 1;
  localparam int unsigned HARM_W   = 18;

  localparam logic signed [DIFF_W-1:0] HARM_MAX = DIFF_W'(131071);
  localparam logic signed [DIFF_W-1:0] HARM_MIN = -DIFF_W'(131072);

  // Rounding offset for the 2/N coefficient scaling
  localparam logic [PROD_W:0] SCALE_RND = (PROD_W+1)'(CYCLE_SAMPLES / 2);

  // Build-time trig table constants
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
  localparam int unsigned TAYLOR_TERMS = 8;

  typedef logic signed [TRIG_W-1:0] trig_t;
  typedef trig_t trig_rom_t [CYCLE_SAMPLES];

  // Ring memory control from the sequencer
  typedef struct packed {
    logic rd;
    logic wr;
  } ring_ctl_t;

  // One Taylor term ratio: divisor (2k)(2k+1) for sine, (2k-1)(2k) for cosine
  function automatic logic [63:0] series_div(input logic [63:0] v, input int unsigned k,
                                             input bit sin_series);
    logic [63:0] q;
    q = '0;
    if (sin_series) begin
      case (k)
        1: q = v / 6;
        2: q = v / 20;
        3: q = v / 42;
        4: q = v / 72;
        5: q = v / 110;
        6: q = v / 156;
        7: q = v / 210;
        default: q = v / 272;
      endcase
    end else begin
      case (k)
        1: q = v / 2;
        2: q = v / 12;
        3: q = v / 30;
        4: q = v / 56;
        5: q = v / 90;
        6: q = v / 132;
        7: q = v / 182;
        default: q = v / 240;
      endcase
    end
    return q;
  endfunction

  // sin or cos of a Q30 angle in the first quadrant, Q30 result
  function automatic logic signed [63:0] quarter_val(input logic [63:0] th,
                                                     input bit sin_series);
    logic [63:0]        t2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    t2   = (th * th) >> 30;
    term = sin_series ? th : Q30_ONE;
    acc  = signed'(term);
    for (int unsigned k = 1; k <= TAYLOR_TERMS; k++) begin
      term = series_div((term * t2) >> 30, k, sin_series);
      acc  = k[0] ? acc - signed'(term) : acc + signed'(term);
    end
    return acc;
  endfunction

  // Q30 to Q15, round half up, clamp to 0..32767
  function automatic trig_t q30_to_q15(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v < 0) begin
      r = '0;
    end else begin
      r = (v + 64'sd16384) >>> 15;
      if (r > 64'sd32767) begin
        r = 64'sd32767;
      end
    end
    return trig_t'(r);
  endfunction

  function automatic trig_t rom_entry(input int unsigned i, input bit sin_sel);
    int unsigned quad;
    int unsigned rem;
    logic [63:0] th;
    trig_t       sq;
    trig_t       cq;
    trig_t       res;
    quad = (4 * i) / CYCLE_SAMPLES;
    rem  = 4 * i - quad * CYCLE_SAMPLES;
    th   = (Q30_HALF_PI * 64'(rem)) / CYCLE_SAMPLES;
    sq   = q30_to_q15(quarter_val(th, 1'b1));
    cq   = q30_to_q15(quarter_val(th, 1'b0));
    case (quad[1:0])
      2'd0:    res = sin_sel ? sq  : cq;
      2'd1:    res = sin_sel ? cq  : -sq;
      2'd2:    res = sin_sel ? -sq : -cq;
      default: res = sin_sel ? -cq : sq;
    endcase
    return res;
  endfunction

  function automatic trig_rom_t build_rom(input bit sin_sel);
    trig_rom_t rom;
    for (int unsigned i = 0; i < CYCLE_SAMPLES; i++) begin
      rom[i] = rom_entry(i, sin_sel);
    end
    return rom;
  endfunction

  localparam trig_rom_t SIN_ROM = build_rom(1'b1);
  localparam trig_rom_t COS_ROM = build_rom(1'b0);

endpackage

`default_nettype wire

@@ rtl/core/sdft_ring.sv @@
`default_nettype none

module sdft_ring
  import sdft_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire ring_ctl_t                  ctl,
  input  wire logic signed [SAMPLE_W-1:0] wr_data,
  output logic [PHASE_W-1:0]              phase,
  output logic signed [SAMPLE_W-1:0]      old_sample
);

  logic signed [SAMPLE_W-1:0] mem [CYCLE_SAMPLES];
  logic signed [SAMPLE_W-1:0] rd_q_r;
  logic                       old_vld_r;
  logic                       wrapped_r;
  logic [PHASE_W-1:0]         phase_r;
  logic                       last_phase;

  assign last_phase = (phase_r == PHASE_W'(CYCLE_SAMPLES - 1));

  // Sample ring: registered read, write at the current phase
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      rd_q_r <= mem[phase_r];
    end
    if (ctl.wr) begin
      mem[phase_r] <= wr_data;
    end
  end

  // Phase counter; entries are only real once the first period has gone round
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= '0;
      wrapped_r <= 1'b0;
      old_vld_r <= 1'b0;
    end else begin
      if (ctl.rd) begin
        old_vld_r <= wrapped_r;
      end
      if (ctl.wr) begin
        phase_r <= last_phase ? '0 : phase_r + 1'b1;
        if (last_phase) begin
          wrapped_r <= 1'b1;
        end
      end
    end
  end

  assign phase      = phase_r;
  assign old_sample = old_vld_r ? rd_q_r : '0;

endmodule

`default_nettype wire

@@ rtl/core/sliding_dft_harmonic_extractor.sv @@
// Each sample runs the steps XS, OS, XC, OC, FS, FC, SUM, RND and SAT in turn;
//   out_valid rises as SAT ends with the output slot free. A single 40x16
//   multiplier is shared over six products per sample under the step sequencer.
// in_ready is high only while the sequencer idles; a result still held when the
//   next one reaches the saturate step stalls the sequencer there.
// Reset (rst_n, synchronous, active low): coefficients and phase cleared at once;
//   the ring reads as zero until the first period has been written.
`default_nettype none

module sliding_dft_harmonic_extractor
  import sdft_pkg::*;
(
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [SAMPLE_W-1:0] in_sample,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [HARM_W-1:0]        out_harmonic
);

  typedef enum logic [9:0] {
    ST_IDLE = 10'b00_0000_0001,
    ST_XS   = 10'b00_0000_0010,
    ST_OS   = 10'b00_0000_0100,
    ST_XC   = 10'b00_0000_1000,
    ST_OC   = 10'b00_0001_0000,
    ST_FS   = 10'b00_0010_0000,
    ST_FC   = 10'b00_0100_0000,
    ST_SUM  = 10'b00_1000_0000,
    ST_RND  = 10'b01_0000_0000,
    ST_SAT  = 10'b10_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic                       in_acc;
  ring_ctl_t                  ring_ctl;
  logic [PHASE_W-1:0]         phase;
  logic signed [SAMPLE_W-1:0] old_sample;

  logic signed [SAMPLE_W-1:0] x_r;
  trig_t                      s_r;
  trig_t                      c_r;
  logic signed [COEF_W-1:0]   sc_r, sc_nxt;
  logic signed [COEF_W-1:0]   cc_r, cc_nxt;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [PROD_W-1:0]   fund_acc_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic signed [FUND_W-1:0]   fund_r;
  logic signed [HARM_W-1:0]   out_harmonic_r;
  logic                       out_valid_r;

  logic signed [COEF_W-1:0]   mul_a;
  trig_t                      mul_b;
  logic                       mul_en;
  logic [PROD_W-1:0]          prod_mag;
  logic [PROD_W:0]            scaled;
  logic [COEF_W-1:0]          contrib;
  logic                       sub_op;
  logic signed [SUM_W-1:0]    rnd_sum;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [HARM_W-1:0]   harm_sat;
  logic                       out_free;

  assign in_acc   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign out_free = !out_valid_r || out_ready;

  assign ring_ctl = '{rd: in_acc, wr: (state_r == ST_XS)};

  sdft_ring u_ring (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (ring_ctl),
    .wr_data    (x_r),
    .phase      (phase),
    .old_sample (old_sample)
  );

  // Step sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_XS;
      ST_XS:   state_nxt = ST_OS;
      ST_OS:   state_nxt = ST_XC;
      ST_XC:   state_nxt = ST_OC;
      ST_OC:   state_nxt = ST_FS;
      ST_FS:   state_nxt = ST_FC;
      ST_FC:   state_nxt = ST_SUM;
      ST_SUM:  state_nxt = ST_RND;
      ST_RND:  state_nxt = ST_SAT;
      ST_SAT:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Shared multiplier operand selection
  always_comb begin
    mul_a  = COEF_W'(x_r);
    mul_b  = s_r;
    mul_en = 1'b1;
    unique case (state_r)
      ST_XS: begin mul_a = COEF_W'(x_r);        mul_b = s_r; end
      ST_OS: begin mul_a = COEF_W'(old_sample); mul_b = s_r; end
      ST_XC: begin mul_a = COEF_W'(x_r);        mul_b = c_r; end
      ST_OC: begin mul_a = COEF_W'(old_sample); mul_b = c_r; end
      ST_FS: begin mul_a = sc_r;                mul_b = s_r; end
      ST_FC: begin mul_a = cc_r;                mul_b = c_r; end
      default: mul_en = 1'b0;
    endcase
  end

  // 2/N scaling of the last product, rounded half away from zero
  assign prod_mag = prod_r[PROD_W-1] ? PROD_W'(-prod_r) : PROD_W'(prod_r);
  assign scaled   = ({prod_mag, 1'b0} + SCALE_RND) >> PHASE_W;
  assign contrib  = scaled[COEF_W-1:0];

  // Leaving samples are subtracted; the product sign flips the operation
  assign sub_op = prod_r[PROD_W-1] ^ ((state_r == ST_XC) || (state_r == ST_FS));

  always_comb begin
    sc_nxt = sc_r;
    cc_nxt = cc_r;
    unique case (state_r) inside
      ST_OS, ST_XC: sc_nxt = sub_op ? sc_r - signed'(contrib) : sc_r + signed'(contrib);
      ST_OC, ST_FS: cc_nxt = sub_op ? cc_r - signed'(contrib) : cc_r + signed'(contrib);
      default: ;
    endcase
  end

  // Fundamental rounding: bias is one less for negative sums
  assign rnd_sum = sum_r + SUM_W'(64'd1 << (FRAC_W - 1)) - SUM_W'(sum_r[SUM_W-1]);

  // Remainder and saturation
  assign diff = DIFF_W'(x_r) - DIFF_W'(fund_r);
  always_comb begin
    if (diff > HARM_MAX) begin
      harm_sat = HARM_W'(HARM_MAX);
    end else if (diff < HARM_MIN) begin
      harm_sat = HARM_W'(HARM_MIN);
    end else begin
      harm_sat = HARM_W'(diff);
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_r <= in_sample;
      s_r <= SIN_ROM[phase];
      c_r <= COS_ROM[phase];
    end
    if (mul_en) begin
      prod_r <= mul_a * mul_b;
    end
    if (state_r == ST_FC) begin
      fund_acc_r <= prod_r;
    end
    if (state_r == ST_SUM) begin
      sum_r <= SUM_W'(fund_acc_r) + SUM_W'(prod_r);
    end
    if (state_r == ST_RND) begin
      fund_r <= rnd_sum[SUM_W-1:FRAC_W];
    end
    if ((state_r == ST_SAT) && out_free) begin
      out_harmonic_r <= harm_sat;
    end
  end

  // Control and coefficient state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      sc_r        <= '0;
      cc_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sc_r    <= sc_nxt;
      cc_r    <= cc_nxt;
      if ((state_r == ST_SAT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_harmonic = out_harmonic_r;

endmodule

`default_nettype wire

@@ rtl/core/sdft_checker.sv @@
`default_nettype none

module sdft_checker
  import sdft_pkg::*;
(
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic signed [SAMPLE_W-1:0] in_sample,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire logic signed [HARM_W-1:0]   out_harmonic
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // Block is busy right after taking a sample
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready ##1 !in_ready)
    else $error("in_ready high while a sample is in progress");

  // A result is on offer after the sample has passed through the SAT step
  a_result_due: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> ##10 out_valid)
    else $error("result missing after input transaction");

  // A new result only appears at the end of a busy period
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a sample in progress");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_harmonic))
    else $error("stalled result changed or dropped");

endmodule

bind sliding_dft_harmonic_extractor sdft_checker u_sdft_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .in_sample    (in_sample),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .out_harmonic (out_harmonic)
);

`default_nettype wire
